// ===== hw/rtl/csvtok_pkg.sv =====
// csvtok_pkg: shared types and constants of the csv field tokeniser
// parse mode codes, register indexes, result beat and decode decision types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package csvtok_pkg;

   localparam logic [2:0] MODE_REC_START   = 3'd0;
   localparam logic [2:0] MODE_FIELD_START = 3'd1;
   localparam logic [2:0] MODE_UNQUOTED    = 3'd2;
   localparam logic [2:0] MODE_QUOTED      = 3'd3;
   localparam logic [2:0] MODE_QUOTE_SEEN  = 3'd4;

   localparam logic [1:0] REG_FIELD_SEP  = 2'd0;
   localparam logic [1:0] REG_RECORD_SEP = 2'd1;
   localparam logic [1:0] REG_QUOTE_CHAR = 2'd2;

   localparam logic [7:0] FIELD_SEP_RESET  = 8'd44;
   localparam logic [7:0] RECORD_SEP_RESET = 8'd10;
   localparam logic [7:0] QUOTE_CHAR_RESET = 8'd34;

   typedef struct packed {
      logic [7:0] content_byte;
      logic       content_valid;
      logic       field_done;
      logic       record_done;
      logic       unmatched_quote;
      logic       final_result;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
      logic [2:0] next_mode;
   } decision_type;

   typedef struct packed {
      logic [7:0] field_sep;
      logic [7:0] record_sep;
      logic [7:0] quote_char;
   } config_type;

endpackage

`default_nettype wire

// ===== hw/rtl/csvtok_decode.sv =====
// csvtok_decode: per-byte tokeniser decision, combinational
// maps parse mode, text byte and end flag to up to two result beats and next mode
// depends on csvtok_pkg
`timescale 1ns / 1ps
`default_nettype none

module csvtok_decode (
   input  wire logic [2:0]             mode,
   input  wire logic [7:0]             text_byte,
   input  wire logic                   end_of_input,
   input  wire csvtok_pkg::config_type cfg,
   output csvtok_pkg::decision_type    decision
);

   logic is_quote;
   logic is_rec;
   logic is_fld;
   csvtok_pkg::result_type blank;
   csvtok_pkg::result_type rec_end;
   csvtok_pkg::result_type fld_end;
   csvtok_pkg::result_type err;
   csvtok_pkg::result_type content;
   csvtok_pkg::result_type plain_content;

   assign is_quote = (text_byte == cfg.quote_char);
   assign is_rec   = (text_byte == cfg.record_sep);
   assign is_fld   = (text_byte == cfg.field_sep);

   always_comb begin
      blank = '0;
      rec_end = '0;
      rec_end.field_done  = 1'b1;
      rec_end.record_done = 1'b1;
      fld_end = '0;
      fld_end.field_done = 1'b1;
      err = '0;
      err.unmatched_quote = 1'b1;
      plain_content = '0;
      plain_content.content_byte  = text_byte;
      plain_content.content_valid = 1'b1;
      content = plain_content;
      content.field_done  = end_of_input;
      content.record_done = end_of_input;
   end

   always_comb begin
      decision = '0;
      decision.res0 = blank;
      decision.res1 = blank;
      decision.next_mode = csvtok_pkg::MODE_REC_START;
      unique case (mode)
         csvtok_pkg::MODE_UNQUOTED: begin
            if (is_rec) begin
               decision.count = 2'd1;
               decision.res0  = rec_end;
            end else if (is_fld) begin
               decision.res0 = fld_end;
               if (end_of_input) begin
                  decision.count = 2'd2;
                  decision.res1  = rec_end;
               end else begin
                  decision.count     = 2'd1;
                  decision.next_mode = csvtok_pkg::MODE_FIELD_START;
               end
            end else begin
               decision.count = 2'd1;
               decision.res0  = content;
               if (!end_of_input) begin
                  decision.next_mode = csvtok_pkg::MODE_UNQUOTED;
               end
            end
         end
         csvtok_pkg::MODE_QUOTED: begin
            if (is_quote) begin
               if (end_of_input) begin
                  decision.count = 2'd1;
                  decision.res0  = rec_end;
               end else begin
                  decision.next_mode = csvtok_pkg::MODE_QUOTE_SEEN;
               end
            end else if (end_of_input) begin
               decision.count = 2'd1;
               decision.res0  = err;
            end else begin
               decision.count     = 2'd1;
               decision.res0      = plain_content;
               decision.next_mode = csvtok_pkg::MODE_QUOTED;
            end
         end
         csvtok_pkg::MODE_QUOTE_SEEN: begin
            if (is_quote) begin
               decision.count = 2'd1;
               if (end_of_input) begin
                  decision.res0 = err;
               end else begin
                  decision.res0      = plain_content;
                  decision.next_mode = csvtok_pkg::MODE_QUOTED;
               end
            end else if (is_rec) begin
               decision.count = 2'd1;
               decision.res0  = rec_end;
            end else begin
               decision.res0 = fld_end;
               if (end_of_input) begin
                  decision.count = 2'd2;
                  decision.res1  = rec_end;
               end else begin
                  decision.count     = 2'd1;
                  decision.next_mode = csvtok_pkg::MODE_FIELD_START;
               end
            end
         end
         default: begin
            if (is_quote) begin
               if (end_of_input) begin
                  decision.count = 2'd1;
                  decision.res0  = err;
               end else begin
                  decision.next_mode = csvtok_pkg::MODE_QUOTED;
               end
            end else if (is_rec) begin
               decision.count = 2'd1;
               decision.res0  = rec_end;
            end else if (is_fld) begin
               decision.res0 = fld_end;
               if (end_of_input) begin
                  decision.count = 2'd2;
                  decision.res1  = rec_end;
               end else begin
                  decision.count     = 2'd1;
                  decision.next_mode = csvtok_pkg::MODE_FIELD_START;
               end
            end else begin
               decision.count = 2'd1;
               decision.res0  = content;
               if (!end_of_input) begin
                  decision.next_mode = csvtok_pkg::MODE_UNQUOTED;
               end
            end
         end
      endcase
      if (decision.count == 2'd1) begin
         decision.res0.final_result = 1'b1;
      end
      if (decision.count == 2'd2) begin
         decision.res1.final_result = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/csv_field_tokenizer_unit.sv =====
// csv_field_tokenizer_unit: streaming csv tokeniser top level
// input register, per-byte decode, two-beat result queue and register file
// depends on csvtok_pkg and csvtok_decode
//
// Usage: text bytes enter on the req_ channel (valid/stall), one byte per beat,
// req_end_of_input set on the last byte of a buffer. Each byte gives zero, one
// or two result beats on the rsp_ channel: a content byte and/or field and
// record end marks, or an unmatched quote flag; rsp_final_result marks the last
// beat caused by a byte. Separators and the quote byte are set through the
// APB-style port at addresses 0, 4 and 8; the user must write them only while
// the block is idle, which the block itself does not enforce. A byte passes
// through the input register and then the result queue before its first
// result beat is offered. Throughput: one byte per cycle while each byte
// yields at most one beat and the receiver does not stall; the result queue
// holds two beats, so a byte with two beats waits for an empty queue and
// leaves it full, and the next byte with a beat waits for room. When the
// receiver stalls, the queue fills and req_stall rises once the held byte
// cannot move on; nothing is lost. Reset clears the input register, the
// queue and the parse mode (record start) and restores the default separators.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_tokenizer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_content_byte,
   output logic             rsp_content_valid,
   output logic             rsp_field_done,
   output logic             rsp_record_done,
   output logic             rsp_unmatched_quote,
   output logic             rsp_final_result,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   csvtok_pkg::config_type   cfg_ff;
   logic [2:0]               mode_ff;
   logic                     s1_valid_ff;
   logic [7:0]               s1_byte_ff;
   logic                     s1_eoi_ff;
   csvtok_pkg::decision_type decision;
   logic                     advance;
   logic                     req_take;
   logic                     rsp_take;
   csvtok_pkg::result_type   q0_ff;
   csvtok_pkg::result_type   q1_ff;
   csvtok_pkg::result_type   q0_in;
   csvtok_pkg::result_type   q1_in;
   csvtok_pkg::result_type   rem0;
   logic [1:0]               count_ff;
   logic [1:0]               count_in;
   logic [1:0]               rem_cnt;
   logic [1:0]               push_cnt;
   logic                     cfg_write;

   // register file
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.field_sep  <= csvtok_pkg::FIELD_SEP_RESET;
         cfg_ff.record_sep <= csvtok_pkg::RECORD_SEP_RESET;
         cfg_ff.quote_char <= csvtok_pkg::QUOTE_CHAR_RESET;
      end else if (cfg_write) begin
         unique case (paddr[3:2])
            csvtok_pkg::REG_FIELD_SEP:  cfg_ff.field_sep  <= pwdata[7:0];
            csvtok_pkg::REG_RECORD_SEP: cfg_ff.record_sep <= pwdata[7:0];
            csvtok_pkg::REG_QUOTE_CHAR: cfg_ff.quote_char <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         csvtok_pkg::REG_FIELD_SEP:  prdata = {24'd0, cfg_ff.field_sep};
         csvtok_pkg::REG_RECORD_SEP: prdata = {24'd0, cfg_ff.record_sep};
         csvtok_pkg::REG_QUOTE_CHAR: prdata = {24'd0, cfg_ff.quote_char};
         default:                    prdata = 32'd0;
      endcase
   end

   // input register
   assign advance   = s1_valid_ff && ({1'b0, count_ff} + {1'b0, decision.count} <= 3'd2);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_text_byte;
         s1_eoi_ff  <= req_end_of_input;
      end
   end

   csvtok_decode u_decode (
      .mode         (mode_ff),
      .text_byte    (s1_byte_ff),
      .end_of_input (s1_eoi_ff),
      .cfg          (cfg_ff),
      .decision     (decision)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= csvtok_pkg::MODE_REC_START;
      end else if (advance) begin
         mode_ff <= decision.next_mode;
      end
   end

   // result queue, q0 is the head beat
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign rem_cnt   = count_ff - {1'b0, rsp_take};
   assign rem0      = rsp_take ? q1_ff : q0_ff;
   assign push_cnt  = advance ? decision.count : 2'd0;
   assign count_in  = rem_cnt + push_cnt;

   always_comb begin
      if (rem_cnt != 2'd0) begin
         q0_in = rem0;
      end else begin
         q0_in = decision.res0;
      end
      if (rem_cnt == 2'd2) begin
         q1_in = q1_ff;
      end else if (rem_cnt == 2'd1) begin
         q1_in = decision.res0;
      end else begin
         q1_in = decision.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp_content_byte    = q0_ff.content_byte;
   assign rsp_content_valid   = q0_ff.content_valid;
   assign rsp_field_done      = q0_ff.field_done;
   assign rsp_record_done     = q0_ff.record_done;
   assign rsp_unmatched_quote = q0_ff.unmatched_quote;
   assign rsp_final_result    = q0_ff.final_result;

endmodule

`default_nettype wire
